>>> src/mts_pkg.sv
// shared types, op codes and note rom for the melody tone sequencer
// no dependencies; used by mts_engine and melody_tone_sequencer
package mts_pkg;

  // number of melodies that may be requested, at most the four held in the rom
  localparam int NumMelodies = 4;
  localparam int RomMelodies = 4;

  localparam int NowWidth  = 32;
  localparam int IdWidth   = 3;
  localparam int FreqWidth = 11;
  localparam int DurWidth  = 9;
  localparam int PosWidth  = 3;
  localparam int SelWidth  = 2;
  localparam int IdxWidth  = 5;

  localparam int InDataWidth  = 40;
  localparam int InUserWidth  = 2;
  localparam int OutDataWidth = 16;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpPlay   = 2'd1,
    OpSilent = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]           op;
    logic [NowWidth-1:0]  now_ms;
    logic [IdWidth-1:0]   melody_id;
    logic                 silent_value;
  } item_t;

  typedef struct packed {
    logic                 tone_on;
    logic [FreqWidth-1:0] tone_freq;
    logic                 playing;
  } result_t;

  // frequency of a rom entry, zero past the end
  function automatic logic [FreqWidth-1:0] note_freq(input logic [IdxWidth-1:0] idx);
    logic [FreqWidth-1:0] f;
    case (idx)
      5'd0:    f = 11'd523;
      5'd1:    f = 11'd659;
      5'd2:    f = 11'd523;
      5'd3:    f = 11'd659;
      5'd4:    f = 11'd784;
      5'd5:    f = 11'd1047;
      5'd6:    f = 11'd784;
      5'd7:    f = 11'd1047;
      5'd8:    f = 11'd392;
      5'd9:    f = 11'd523;
      5'd10:   f = 11'd659;
      5'd11:   f = 11'd784;
      5'd12:   f = 11'd1047;
      5'd13:   f = 11'd200;
      5'd14:   f = 11'd150;
      default: f = 11'd0;
    endcase
    return f;
  endfunction

  // duration in ms of a rom entry, zero past the end
  function automatic logic [DurWidth-1:0] note_dur(input logic [IdxWidth-1:0] idx);
    logic [DurWidth-1:0] d;
    case (idx)
      5'd0, 5'd1:                         d = 9'd120;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6:       d = 9'd100;
      5'd7, 5'd13, 5'd14:                 d = 9'd200;
      5'd8, 5'd9, 5'd10, 5'd11:           d = 9'd150;
      5'd12:                              d = 9'd300;
      default:                            d = 9'd0;
    endcase
    return d;
  endfunction

  // first rom entry of each melody
  function automatic logic [IdxWidth-1:0] mel_base(input logic [SelWidth-1:0] sel);
    logic [IdxWidth-1:0] b;
    case (sel)
      2'd0:    b = 5'd0;
      2'd1:    b = 5'd2;
      2'd2:    b = 5'd8;
      default: b = 5'd13;
    endcase
    return b;
  endfunction

  // number of notes in each melody
  function automatic logic [PosWidth-1:0] mel_len(input logic [SelWidth-1:0] sel);
    logic [PosWidth-1:0] l;
    case (sel)
      2'd0:    l = 3'd2;
      2'd1:    l = 3'd6;
      2'd2:    l = 3'd5;
      default: l = 3'd2;
    endcase
    return l;
  endfunction

endpackage

>>> src/mts_engine.sv
// sequencer state and the single-step update for one item
// depends on mts_pkg for item and result types and the note rom
module mts_engine
  import mts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic                 active_q, active_d;
  logic [SelWidth-1:0]  sel_q, sel_d;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [NowWidth-1:0]  start_q, start_d;
  logic                 mute_q, mute_d;
  logic                 drive_on_q, drive_on_d;
  logic [FreqWidth-1:0] drive_freq_q, drive_freq_d;

  logic [PosWidth-1:0]  len;
  logic [PosWidth-1:0]  next_pos;
  logic [IdxWidth-1:0]  cur_idx;
  logic [IdxWidth-1:0]  next_idx;
  logic [NowWidth-1:0]  elapsed;
  logic [SelWidth-1:0]  req_sel;
  logic                 id_ok;

  // rom lookups for the current and next note
  assign len      = mel_len(sel_q);
  assign next_pos = pos_q + 3'd1;
  assign cur_idx  = mel_base(sel_q) + IdxWidth'(pos_q);
  assign next_idx = mel_base(sel_q) + IdxWidth'(next_pos);
  assign elapsed  = item_i.now_ms - start_q;
  assign req_sel  = item_i.melody_id[SelWidth-1:0];
  assign id_ok    = (int'(item_i.melody_id) < NumMelodies)
                 && (int'(item_i.melody_id) < RomMelodies);

  // next state for the item
  always_comb begin
    active_d     = active_q;
    sel_d        = sel_q;
    pos_d        = pos_q;
    start_d      = start_q;
    mute_d       = mute_q;
    drive_on_d   = drive_on_q;
    drive_freq_d = drive_freq_q;
    case (op_e'(item_i.op))
      OpTick: begin
        if (active_q && !mute_q) begin
          if (pos_q >= len) begin
            active_d     = 1'b0;
            drive_on_d   = 1'b0;
            drive_freq_d = '0;
          end else if (elapsed >= NowWidth'(note_dur(cur_idx))) begin
            pos_d = next_pos;
            if (next_pos < len) begin
              start_d      = item_i.now_ms;
              drive_on_d   = 1'b1;
              drive_freq_d = note_freq(next_idx);
            end else begin
              active_d     = 1'b0;
              drive_on_d   = 1'b0;
              drive_freq_d = '0;
            end
          end
        end
      end
      OpPlay: begin
        if (id_ok) begin
          active_d = 1'b1;
          sel_d    = req_sel;
          pos_d    = '0;
          start_d  = item_i.now_ms;
          if (!mute_q) begin
            drive_on_d   = 1'b1;
            drive_freq_d = note_freq(mel_base(req_sel));
          end
        end
      end
      OpSilent: begin
        mute_d = item_i.silent_value;
        if (item_i.silent_value) begin
          drive_on_d   = 1'b0;
          drive_freq_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result seen after the item
  always_comb begin
    result_o.tone_on   = drive_on_d;
    result_o.tone_freq = drive_on_d ? drive_freq_d : '0;
    result_o.playing   = active_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      sel_q        <= '0;
      pos_q        <= '0;
      start_q      <= '0;
      mute_q       <= 1'b0;
      drive_on_q   <= 1'b0;
      drive_freq_q <= '0;
    end else if (fire_i) begin
      active_q     <= active_d;
      sel_q        <= sel_d;
      pos_q        <= pos_d;
      start_q      <= start_d;
      mute_q       <= mute_d;
      drive_on_q   <= drive_on_d;
      drive_freq_q <= drive_freq_d;
    end
  end

endmodule

>>> src/melody_tone_sequencer.sv
// Melody tone sequencer: takes one item per clock cycle (tick, play request or
// silent write, selected by s_axis_tuser) while the output is not stalled, and
// returns one result item for each, registered in the input register and then the
// result register. The rate is set by the single update step between the two,
// where the note rom read and the 32-bit elapsed-time compare sit.
// depends on mts_pkg and mts_engine
module melody_tone_sequencer
  import mts_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [31:0] now_ms, [34:32] melody_id, [35] silent_value, [39:36] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [InUserWidth-1:0]  s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] tone_on, [11:1] tone_freq, [12] playing, [15:13] zero
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    advance;
  result_t step_res;

  // handshake: the step runs when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.op           <= s_axis_tuser;
      in_item_q.now_ms       <= s_axis_tdata[31:0];
      in_item_q.melody_id    <= s_axis_tdata[34:32];
      in_item_q.silent_value <= s_axis_tdata[35];
    end
  end

  mts_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (step_res)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.playing, out_res_q.tone_freq, out_res_q.tone_on};

`ifndef SYNTHESIS
  // an empty result register never holds back the input
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with free result register");

  // a sounding tone belongs to an active melody
  a_tone_needs_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.tone_on) |-> out_res_q.playing)
    else $error("tone on while idle");

  // frequency reads zero while the tone is off
  a_freq_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.tone_on) |-> (out_res_q.tone_freq == '0))
    else $error("nonzero frequency with tone off");

  // a step always loads the result register
  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after step");
`endif

endmodule

>>> test/tb.sv
// self-checking testbench for melody_tone_sequencer: a driver, a monitor and a tone predictor
// drives directed and random tick, play and silent items and checks every result item
// depends on mts_pkg and melody_tone_sequencer
module tb
  import mts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // op code the block does not know
  localparam logic [1:0] OpUnused = 2'd3;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 1650;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned IdlePercent = 22;

  typedef struct {
    item_t word;
    bit    settle;  // wait until every result has come before offering this item
  } pending_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [31:0] now_ms, [34:32] melody_id, [35] silent_value, [39:36] zero
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  // [1:0] op
  logic [InUserWidth-1:0]  s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [0] tone_on, [11:1] tone_freq, [12] playing, [15:13] zero
  logic [OutDataWidth-1:0] m_axis_tdata;

  pending_t    send_q[$];
  result_t     tone_due_q[$];
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  // note table: frequency and length of every note, melodies back to back
  int unsigned note_hz [15] = '{523, 659, 523, 659, 784, 1047, 784, 1047,
                                392, 523, 659, 784, 1047, 200, 150};
  int unsigned note_ms [15] = '{120, 120, 100, 100, 100, 100, 100, 200,
                                150, 150, 150, 150, 300, 200, 200};
  int unsigned tune_first [4] = '{0, 2, 8, 13};
  int unsigned tune_notes [4] = '{2, 6, 5, 2};

  // predictor state
  bit              run_on = 1'b0;
  logic [1:0]      run_sel = '0;
  logic [2:0]      run_pos = '0;
  logic [31:0]     run_start = '0;
  bit              hush = 1'b0;
  bit              buzz_on = 1'b0;
  logic [10:0]     buzz_hz = '0;

  melody_tone_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10ns clk_i = ~clk_i;

  // one mismatch line, counted
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch on %s at result %0d: got %0d, want %0d", what, got_cnt, got, want);
    errors++;
  endtask

  // advance the tone state by one item and return the outputs it leaves behind
  function automatic result_t predict_tone(input item_t it);
    result_t     res;
    logic [31:0] gap;
    int unsigned len;
    len = tune_notes[run_sel];
    case (it.op)
      OpTick: begin
        if (run_on && !hush) begin
          gap = it.now_ms - run_start;
          if (run_pos >= len) begin
            run_on = 1'b0;
            buzz_on = 1'b0;
            buzz_hz = '0;
          end else if (gap >= note_ms[tune_first[run_sel] + run_pos]) begin
            run_pos = run_pos + 3'd1;
            if (run_pos < len) begin
              run_start = it.now_ms;
              buzz_on = 1'b1;
              buzz_hz = note_hz[tune_first[run_sel] + run_pos];
            end else begin
              run_on = 1'b0;
              buzz_on = 1'b0;
              buzz_hz = '0;
            end
          end
        end
      end
      OpPlay: begin
        if (it.melody_id < NumMelodies && it.melody_id < 4) begin
          run_on = 1'b1;
          run_sel = it.melody_id[1:0];
          run_pos = '0;
          run_start = it.now_ms;
          if (!hush) begin
            buzz_on = 1'b1;
            buzz_hz = note_hz[tune_first[run_sel]];
          end
        end
      end
      OpSilent: begin
        hush = it.silent_value;
        if (it.silent_value) begin
          buzz_on = 1'b0;
          buzz_hz = '0;
        end
      end
      default: ;
    endcase
    res.tone_on = buzz_on;
    res.tone_freq = buzz_on ? buzz_hz : '0;
    res.playing = run_on;
    return res;
  endfunction

  task automatic add_item(input logic [1:0] op, input logic [31:0] now,
                          input logic [2:0] id, input logic sv);
    pending_t p;
    p.word.op = op;
    p.word.now_ms = now;
    p.word.melody_id = id;
    p.word.silent_value = sv;
    p.settle = (send_q.size() == 600 || send_q.size() == 1300);
    send_q.push_back(p);
  endtask

  // sender: offers queued items, predicts each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit       took;
    bit       quiet;
    item_t    seen;
    pending_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      sent_cnt <= 0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        seen.op = s_axis_tuser;
        seen.now_ms = s_axis_tdata[31:0];
        seen.melody_id = s_axis_tdata[34:32];
        seen.silent_value = s_axis_tdata[35];
        tone_due_q.push_back(predict_tone(seen));
        sent_cnt <= sent_cnt + 1;
      end
      // no gaps over a long stretch in the middle of the run
      quiet = (sent_cnt >= 900 && sent_cnt < 1100) ? 1'b0 : ($urandom_range(99) < IdlePercent);
      if (s_axis_tvalid && !took) begin
        // hold the offered item
      end else if (send_q.size() != 0 && !quiet &&
                   (!send_q[0].settle || sent_cnt + took == got_cnt)) begin
        nxt = send_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, nxt.word.silent_value, nxt.word.melody_id, nxt.word.now_ms};
        s_axis_tuser <= nxt.word.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: checks each result item against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    result_t     want;
    int unsigned hold_left;
    bit          held;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      got_cnt <= 0;
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_cnt <= got_cnt + 1;
        if (tone_due_q.size() == 0) begin
          report_mismatch("result with nothing predicted", m_axis_tdata, 0);
        end else begin
          want = tone_due_q.pop_front();
          if (m_axis_tdata[0] !== want.tone_on)
            report_mismatch("tone_on", m_axis_tdata[0], want.tone_on);
          if (m_axis_tdata[11:1] !== want.tone_freq)
            report_mismatch("tone_freq", m_axis_tdata[11:1], want.tone_freq);
          if (m_axis_tdata[12] !== want.playing)
            report_mismatch("playing", m_axis_tdata[12], want.playing);
        end
      end
      // one long hold-off so that the block fills up and stalls its input
      if (!held && got_cnt >= 300) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (got_cnt >= 900 && got_cnt < 1100) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [31:0] t;
    logic [2:0]  id;
    int unsigned steps;
    int unsigned pick;
    int unsigned base_cnt;

    // directed: idle tick, unknown op, out-of-range melodies
    add_item(OpTick, 32'd0, 3'd0, 1'b0);
    add_item(OpUnused, 32'hFFFF_FFFF, 3'd7, 1'b1);
    add_item(OpPlay, 32'd100, 3'd7, 1'b0);
    add_item(OpPlay, 32'd100, 3'd4, 1'b1);
    // melody 0 across the time wrap: one short of the note length, then exact
    add_item(OpPlay, 32'hFFFF_FFC0, 3'd0, 1'b0);
    add_item(OpTick, 32'h0000_0037, 3'd5, 1'b1);
    add_item(OpTick, 32'h0000_0038, 3'd2, 1'b0);
    // silence mid-note, frozen tick, unsilence keeps the tone off, then run off the end
    add_item(OpSilent, 32'd0, 3'd0, 1'b1);
    add_item(OpTick, 32'h0000_1000, 3'd0, 1'b0);
    add_item(OpSilent, 32'hFFFF_FFFF, 3'd7, 1'b0);
    add_item(OpTick, 32'h0000_1000, 3'd0, 1'b0);
    // play while silent, then unsilence and wait for the next note
    add_item(OpSilent, 32'd0, 3'd0, 1'b1);
    add_item(OpPlay, 32'd500, 3'd2, 1'b0);
    add_item(OpTick, 32'd700, 3'd0, 1'b0);
    add_item(OpSilent, 32'd0, 3'd0, 1'b0);
    add_item(OpTick, 32'd649, 3'd0, 1'b0);
    add_item(OpTick, 32'd650, 3'd0, 1'b0);
    // melody 3 to the end
    add_item(OpPlay, 32'd1000, 3'd3, 1'b0);
    add_item(OpTick, 32'd1200, 3'd0, 1'b0);
    add_item(OpTick, 32'd1399, 3'd0, 1'b0);
    add_item(OpTick, 32'd1400, 3'd0, 1'b0);
    // melody 1 through its notes, one tick per note
    add_item(OpPlay, 32'd2000, 3'd1, 1'b0);
    for (int k = 1; k <= 5; k++) add_item(OpTick, 32'd2000 + 100 * k, 3'd0, 1'b0);
    add_item(OpTick, 32'd2700, 3'd0, 1'b0);

    // random runs: play a melody, then mostly ticks with some noise in between
    base_cnt = send_q.size();
    t = $urandom();
    while (send_q.size() < base_cnt + RandomItems) begin
      if ($urandom_range(3) == 0) t = $urandom();
      else t = t + $urandom_range(0, 500);
      id = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      if ($urandom_range(9) == 0) add_item(OpSilent, $urandom(), 3'($urandom()), 1'b1);
      add_item(OpPlay, t, id, 1'($urandom()));
      steps = $urandom_range(3, 14);
      repeat (steps) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          add_item(OpSilent, $urandom(), 3'($urandom()), 1'($urandom()));
        end else if (pick < 11) begin
          add_item(2'($urandom()), $urandom(), 3'($urandom()), 1'($urandom()));
        end else if (pick < 14) begin
          add_item(OpPlay, t, 3'($urandom()), 1'($urandom()));
        end else begin
          t = t + $urandom_range(0, 220);
          add_item(OpTick, t, 3'($urandom()), 1'($urandom()));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // wait for the stimulus to drain and every result to come back
    while (send_q.size() != 0 || s_axis_tvalid || sent_cnt != got_cnt) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tone_due_q.size() != 0) report_mismatch("results never seen", 0, tone_due_q.size());
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
